### rtl/core/time_derivative_stencil_stats_defines.svh
// ----------------------------------------------------------------------------
// time_derivative_stencil_stats_defines
// Assertion macros used by the checker of the derivative stencil block.
// ----------------------------------------------------------------------------
`ifndef TIME_DERIVATIVE_STENCIL_STATS_DEFINES_SVH
`define TIME_DERIVATIVE_STENCIL_STATS_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define TDSS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define TDSS_ASSERT(lbl, prop, msg) `TDSS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/tdss_pkg.sv
// ----------------------------------------------------------------------------
// tdss_pkg
// Widths, register codes and beat types of the derivative stencil block.
// ----------------------------------------------------------------------------
`default_nettype none

package tdss_pkg;

  localparam int unsigned SampleW        = 32;
  localparam int unsigned ScaleW         = 32;
  localparam int unsigned IdxW           = 12;
  localparam int unsigned SumSqW         = 64;
  localparam int unsigned FracBits       = 16;
  localparam int unsigned MaxElementsDef = 4096;
  localparam int unsigned WindowDepth    = 5;
  localparam int unsigned HeldSlots      = WindowDepth - 1;
  localparam int unsigned LaneW          = $clog2(HeldSlots);
  localparam int unsigned HeldW          = $clog2(HeldSlots + 1);

  localparam int unsigned CfgIdxW        = 1;
  localparam logic [CfgIdxW-1:0] RegScaleFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegScaleSecond = 1'b1;
  localparam logic [ScaleW-1:0]  ScaleReset     = 32'h0001_0000;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_in_snapshot;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0] first_derivative;
    logic signed [SampleW-1:0] second_derivative;
    logic [IdxW-1:0]           element_index;
    logic                      window_done;
    logic signed [SampleW-1:0] first_min;
    logic signed [SampleW-1:0] first_max;
    logic [SumSqW-1:0]         first_sum_squares;
    logic signed [SampleW-1:0] second_min;
    logic signed [SampleW-1:0] second_max;
    logic [SumSqW-1:0]         second_sum_squares;
  } out_beat_t;

endpackage

`default_nettype wire

### rtl/core/tdss_if.sv
// ----------------------------------------------------------------------------
// tdss_if
// Valid/ready channels for sample beats in and derivative beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdss_in_if;
  import tdss_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tdss_out_if;
  import tdss_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/time_derivative_stencil_stats.sv
// ----------------------------------------------------------------------------
// time_derivative_stencil_stats
// Fourth-order centered first and second time derivatives over a stream of
// snapshots, with per-snapshot min, max and saturating sum of squares.
// ----------------------------------------------------------------------------
// The four previous snapshots live in one ring store of MaxElements rows, each
// row holding the same element of all four snapshots in four 32-bit lanes.
// A sample beat that produces no result (ring still filling, or element past
// MaxElements) leaves the input ready. A producing beat goes through accept
// with row read and lane write, stencil sum, split scale multiply, rounding
// and saturation, squaring and the load of the output register, which waits
// while an earlier result beat is held; input is not ready until that load.
// The store needs no clearing after reset; entries are read only once written.
`default_nettype none

module time_derivative_stencil_stats #(
  parameter int unsigned MaxElements = tdss_pkg::MaxElementsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tdss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tdss_pkg::ScaleW-1:0]  cfg_wdata_i,
  tdss_in_if.sink                      in_i,
  tdss_out_if.source                   out_o
);
  import tdss_pkg::*;

  localparam int unsigned AddrW = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam int unsigned PosW  = $clog2(MaxElements + 1);
  localparam int unsigned SumW  = 39;
  localparam int unsigned MagW  = 38;
  localparam int unsigned HalfW = MagW / 2;
  localparam int unsigned PartW = HalfW + ScaleW;
  localparam int unsigned ProdW = MagW + ScaleW + 1;
  localparam int unsigned QW    = ProdW - FracBits;
  localparam int unsigned RowW  = HeldSlots * SampleW;
  localparam int unsigned SqrW  = 2 * SampleW;

  localparam logic [ProdW-1:0]        RoundHalf = ProdW'(64'h8000);
  localparam logic [QW-1:0]           NegLimit  = QW'(64'h8000_0000);
  localparam logic [QW-1:0]           PosLimit  = QW'(64'h7FFF_FFFF);
  localparam logic signed [SampleW-1:0] MinVal  = 32'sh8000_0000;
  localparam logic signed [SampleW-1:0] MaxVal  = 32'sh7FFF_FFFF;

  localparam int unsigned StateW = 3;
  localparam logic [StateW-1:0] StIdle = 3'd0;
  localparam logic [StateW-1:0] StSum  = 3'd1;
  localparam logic [StateW-1:0] StMul  = 3'd2;
  localparam logic [StateW-1:0] StRnd  = 3'd3;
  localparam logic [StateW-1:0] StSq   = 3'd4;
  localparam logic [StateW-1:0] StOut  = 3'd5;

  function automatic logic signed [SampleW-1:0] round_sat(input logic [ProdW-1:0] prod,
                                                          input logic neg);
    logic [QW-1:0] q;
    q = QW'(prod >> FracBits);
    if (neg) begin
      if (q > NegLimit) return MinVal;
      return $signed(-SampleW'(q));
    end
    if (q > PosLimit) return MaxVal;
    return $signed(SampleW'(q));
  endfunction

  function automatic logic [SumSqW-1:0] sat_add(input logic [SumSqW-1:0] a,
                                                input logic [SumSqW-1:0] b);
    logic [SumSqW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumSqW] ? '1 : s[SumSqW-1:0];
  endfunction

  // control
  logic [StateW-1:0] state_q, state_d;
  logic [PosW-1:0]   pos_q;
  logic [HeldW-1:0]  held_q;
  logic [LaneW-1:0]  ring_q;
  logic              out_valid_q;
  logic [ScaleW-1:0] scale_first_q, scale_second_q;

  logic in_acc, in_range, full, out_free, load_out, mem_en;
  logic [LaneW-1:0] wr_lane;
  logic [AddrW-1:0] mem_addr;

  // ring store
  logic [RowW-1:0] store_mem [MaxElements];
  logic [RowW-1:0] rd_q;

  // datapath
  logic signed [SampleW-1:0] sample_q;
  logic                      last_q;
  logic [AddrW-1:0]          p_q;
  logic [LaneW-1:0]          base_q;
  logic [MagW-1:0]           mag1_q, mag2_q;
  logic                      neg1_q, neg2_q;
  logic [PartW-1:0]          pl1_q, ph1_q, pl2_q, ph2_q;
  logic signed [SampleW-1:0] d1_q, d2_q;
  logic [SumSqW-1:0]         sq1_q, sq2_q;
  out_beat_t                 out_beat_q, beat_n;

  // statistics
  logic signed [SampleW-1:0] f_low_q, f_high_q, s_low_q, s_high_q;
  logic [SumSqW-1:0]         f_acc_q, s_acc_q;
  logic signed [SampleW-1:0] f_low_n, f_high_n, s_low_n, s_high_n;
  logic [SumSqW-1:0]         f_acc_n, s_acc_n;
  logic                      first_p;

  logic [LaneW-1:0]          lane_of [HeldSlots];
  logic signed [SampleW-1:0] v [HeldSlots];
  logic signed [SumW-1:0]    e0, e1, e2, e3, e4, s1, s2;
  logic [ProdW-1:0]          prod1, prod2;
  logic signed [SqrW-1:0]    sqr1, sqr2;

  assign in_i.ready    = (state_q == StIdle);
  assign in_acc        = in_i.valid && in_i.ready;
  assign in_range      = pos_q < PosW'(MaxElements);
  assign full          = (held_q == HeldW'(HeldSlots));
  assign wr_lane       = full ? ring_q : ring_q + held_q[LaneW-1:0];
  assign mem_addr      = pos_q[AddrW-1:0];
  assign mem_en        = in_acc && in_range;
  assign out_free      = !out_valid_q || out_o.ready;
  assign load_out      = (state_q == StOut) && out_free;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_beat_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (mem_en && full) state_d = StSum;
      end
      StSum: state_d = StMul;
      StMul: state_d = StRnd;
      StRnd: state_d = StSq;
      StSq:  state_d = StOut;
      StOut: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      pos_q          <= '0;
      held_q         <= '0;
      ring_q         <= '0;
      out_valid_q    <= 1'b0;
      scale_first_q  <= ScaleReset;
      scale_second_q <= ScaleReset;
      f_low_q        <= '0;
      f_high_q       <= '0;
      f_acc_q        <= '0;
      s_low_q        <= '0;
      s_high_q       <= '0;
      s_acc_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegScaleFirst:  scale_first_q  <= cfg_wdata_i;
          RegScaleSecond: scale_second_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_i.payload.last_in_snapshot) begin
          pos_q <= '0;
          if (full) ring_q <= ring_q + LaneW'(1);
          else held_q <= held_q + HeldW'(1);
        end else if (in_range) begin
          pos_q <= pos_q + PosW'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        f_low_q     <= f_low_n;
        f_high_q    <= f_high_n;
        f_acc_q     <= f_acc_n;
        s_low_q     <= s_low_n;
        s_high_q    <= s_high_n;
        s_acc_q     <= s_acc_n;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // one row per element, one lane per held snapshot
  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      for (int l = 0; l < HeldSlots; l++) begin
        if (wr_lane == LaneW'(l)) begin
          store_mem[mem_addr][l*SampleW +: SampleW] <= in_i.payload.sample;
        end
      end
      rd_q <= store_mem[mem_addr];
    end
  end

  // stencil sums, oldest snapshot first
  always_comb begin
    for (int k = 0; k < HeldSlots; k++) begin
      lane_of[k] = base_q + LaneW'(k);
    end
    for (int k = 0; k < HeldSlots; k++) begin
      v[k] = $signed(rd_q[lane_of[k]*SampleW +: SampleW]);
    end
    e0 = SumW'(v[0]);
    e1 = SumW'(v[1]);
    e2 = SumW'(v[2]);
    e3 = SumW'(v[3]);
    e4 = SumW'(sample_q);
    s1 = e0 - (e1 <<< 3) + (e3 <<< 3) - e4;
    // 16 v1 - 30 v2 + 16 v3 - v0 - v4
    s2 = (e1 <<< 4) + (e3 <<< 4) - (e2 <<< 5) + (e2 <<< 1) - e0 - e4;
  end

  assign prod1 = (ProdW'(ph1_q) << HalfW) + ProdW'(pl1_q) + RoundHalf;
  assign prod2 = (ProdW'(ph2_q) << HalfW) + ProdW'(pl2_q) + RoundHalf;
  assign sqr1  = SqrW'(d1_q) * SqrW'(d1_q);
  assign sqr2  = SqrW'(d2_q) * SqrW'(d2_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.payload.sample;
      last_q   <= in_i.payload.last_in_snapshot;
      p_q      <= pos_q[AddrW-1:0];
      base_q   <= ring_q;
    end
    if (state_q == StSum) begin
      neg1_q <= s1[SumW-1];
      neg2_q <= s2[SumW-1];
      mag1_q <= MagW'(s1[SumW-1] ? -s1 : s1);
      mag2_q <= MagW'(s2[SumW-1] ? -s2 : s2);
    end
    if (state_q == StMul) begin
      pl1_q <= PartW'(mag1_q[HalfW-1:0]) * PartW'(scale_first_q);
      ph1_q <= PartW'(mag1_q[MagW-1:HalfW]) * PartW'(scale_first_q);
      pl2_q <= PartW'(mag2_q[HalfW-1:0]) * PartW'(scale_second_q);
      ph2_q <= PartW'(mag2_q[MagW-1:HalfW]) * PartW'(scale_second_q);
    end
    if (state_q == StRnd) begin
      d1_q <= round_sat(prod1, neg1_q);
      d2_q <= round_sat(prod2, neg2_q);
    end
    if (state_q == StSq) begin
      sq1_q <= SumSqW'(sqr1);
      sq2_q <= SumSqW'(sqr2);
    end
    if (load_out) out_beat_q <= beat_n;
  end

  // running statistics, restarted on element zero
  always_comb begin
    first_p  = (p_q == '0);
    f_low_n  = (first_p || d1_q < f_low_q)  ? d1_q : f_low_q;
    f_high_n = (first_p || d1_q > f_high_q) ? d1_q : f_high_q;
    s_low_n  = (first_p || d2_q < s_low_q)  ? d2_q : s_low_q;
    s_high_n = (first_p || d2_q > s_high_q) ? d2_q : s_high_q;
    f_acc_n  = first_p ? sq1_q : sat_add(f_acc_q, sq1_q);
    s_acc_n  = first_p ? sq2_q : sat_add(s_acc_q, sq2_q);

    beat_n                    = '0;
    beat_n.first_derivative   = d1_q;
    beat_n.second_derivative  = d2_q;
    beat_n.element_index      = IdxW'(p_q);
    beat_n.window_done        = last_q;
    if (last_q) begin
      beat_n.first_min          = f_low_n;
      beat_n.first_max          = f_high_n;
      beat_n.first_sum_squares  = f_acc_n;
      beat_n.second_min         = s_low_n;
      beat_n.second_max         = s_high_n;
      beat_n.second_sum_squares = s_acc_n;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tdss_checker.sv
// ----------------------------------------------------------------------------
// tdss_checker
// Port-level checks on the result channel of the derivative stencil block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "time_derivative_stencil_stats_defines.svh"

module tdss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input tdss_pkg::out_beat_t out_beat_i
);
  import tdss_pkg::*;

  logic stall, done, open, stats_zero, first_in, second_in;

  assign stall      = out_valid_i && !out_ready_i;
  assign done       = out_valid_i && out_beat_i.window_done;
  assign open       = out_valid_i && !out_beat_i.window_done;
  assign stats_zero = (out_beat_i.first_min == '0) && (out_beat_i.first_max == '0)
                   && (out_beat_i.first_sum_squares == '0)
                   && (out_beat_i.second_min == '0) && (out_beat_i.second_max == '0)
                   && (out_beat_i.second_sum_squares == '0);
  assign first_in   = (out_beat_i.first_min <= out_beat_i.first_derivative)
                   && (out_beat_i.first_derivative <= out_beat_i.first_max);
  assign second_in  = (out_beat_i.second_min <= out_beat_i.second_derivative)
                   && (out_beat_i.second_derivative <= out_beat_i.second_max);

  `TDSS_ASSERT(a_out_hold, stall |=> out_valid_i && $stable(out_beat_i), "result beat dropped")
  `TDSS_ASSERT(a_stats_zero, open |-> stats_zero, "statistics set on open snapshot")
  `TDSS_ASSERT(a_first_range, done |-> first_in, "first derivative outside min max")
  `TDSS_ASSERT(a_second_range, done |-> second_in, "second derivative outside min max")

endmodule

bind time_derivative_stencil_stats tdss_checker u_tdss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.payload)
);

`default_nettype wire
